// ----- hw/rtl/cfa_pkg.sv -----
// cfa_pkg: shared constants and codes for the contiguous fit allocator
// word field widths, request function codes, result status codes and fit policy codes
// no dependencies
package cfa_pkg;

  // word field widths
  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned FBASE_W  = 6;
  localparam int unsigned ABASE_W  = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FREEC_W  = 7;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [FUNC_W-1:0]   func_t;

  // request function codes
  localparam func_t FN_ALLOC = 1'b0;
  localparam func_t FN_FREE  = 1'b1;

  // result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_NO_FIT = 2'd2;

  // fit policy
  localparam logic MODE_BEST  = 1'b0;
  localparam logic MODE_WORST = 1'b1;

endpackage

// ----- hw/rtl/contiguous_fit_allocator.sv -----
// contiguous_fit_allocator: best/worst fit allocator over a map of used/free cells
// holds the cell map memory, the scan/mark/free sequencer and the result register
// depends on cfa_pkg
//
// One request word in, one result word out. The block works on one request at
// a time and stalls its input while busy. The cell map sits in a memory with
// one read and one write port that is visited one cell per cycle. An allocate
// that finds a fit goes through a check step, a scan over every cell and one
// position past the end, a base load step, a mark over the requested cells and
// a reply step; an allocate that ends in full, or a zero size allocate, goes
// from the check step straight to the reply step; a free visits
// min(request_size, MEM_CELLS - free_base) cells and then replies. A result
// that is not taken yet does not block acceptance of the next request. The
// map reads as all free right after reset, with no clearing pass. fit_mode may
// only be written while no request is in flight.
module contiguous_fit_allocator
  import cfa_pkg::*;
#(
  parameter int unsigned MEM_CELLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_fit_mode,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [SIZE_W-1:0]   in_request_size,
  input  logic [FBASE_W-1:0]  in_free_base,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ABASE_W-1:0]  out_alloc_base,
  output logic [STATUS_W-1:0] out_status,
  output logic [FREEC_W-1:0]  out_free_cells
);

  localparam int unsigned AW = $clog2(MEM_CELLS);
  localparam int unsigned CW = $clog2(MEM_CELLS + 1);
  localparam int unsigned SW = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int unsigned PW = (CW > FBASE_W) ? CW : FBASE_W;
  localparam int unsigned FW = (CW > FREEC_W) ? CW : FREEC_W;

  // sequencer state codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MARK  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_REPLY = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic                mode_r;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic [PW-1:0]       cur_r, cur_nxt;
  logic [SIZE_W-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]       run_r, run_nxt;
  logic                found_r, found_nxt;
  logic [CW-1:0]       best_len_r, best_len_nxt;
  logic [CW-1:0]       best_end_r, best_end_nxt;
  logic [PW-1:0]       res_base_r, res_base_nxt;
  status_t             res_status_r, res_status_nxt;

  logic                out_valid_r;
  logic [ABASE_W-1:0]  out_base_r;
  status_t             out_status_r;
  logic [FREEC_W-1:0]  out_freec_r;

  // cell map memory plus per-cell written flags
  logic                map_mem [MEM_CELLS];
  logic [MEM_CELLS-1:0] wrt_r;
  logic                rd_bit_r, rd_wrt_r;
  logic                cell_used;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                wr_en, wr_data;

  logic                in_acc;
  logic                slot_free;
  logic [PW:0]         cur_inc;
  logic                last_cell;
  logic                take;
  logic [SW:0]         need_total;
  logic [SW-1:0]       base_calc;
  logic [FW-1:0]       free_calc;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign cell_used = rd_bit_r && rd_wrt_r;
  assign cur_inc   = {1'b0, cur_r} + (PW+1)'(1);
  assign last_cell = (cur_r == PW'(MEM_CELLS));

  assign need_total = (SW+1)'(used_r) + (SW+1)'(size_r);
  assign base_calc  = SW'(best_end_r) - SW'(size_r);

  // run selection: later runs win ties
  always_comb begin
    if (!found_r) begin
      take = 1'b1;
    end else if (mode_r == MODE_BEST) begin
      take = (run_r <= best_len_r);
    end else begin
      take = (run_r >= best_len_r);
    end
  end

  // read address: next cell to look at, or cell 0 when that lies outside the map
  always_comb begin
    rd_addr = '0;
    if (state_r == S_IDLE) begin
      if (in_func == FN_FREE && PW'(in_free_base) < PW'(MEM_CELLS)) begin
        rd_addr = AW'(in_free_base);
      end
    end else if (state_r == S_SCAN || state_r == S_FREE) begin
      if (cur_inc < (PW+1)'(MEM_CELLS)) begin
        rd_addr = cur_inc[AW-1:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    used_nxt       = used_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    run_nxt        = run_r;
    found_nxt      = found_r;
    best_len_nxt   = best_len_r;
    best_end_nxt   = best_end_r;
    res_base_nxt   = res_base_r;
    res_status_nxt = res_status_r;
    wr_en          = 1'b0;
    wr_data        = 1'b0;
    wr_addr        = cur_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          size_nxt     = in_request_size;
          cnt_nxt      = '0;
          res_base_nxt = '0;
          if (in_func == FN_FREE) begin
            cur_nxt   = PW'(in_free_base);
            state_nxt = S_FREE;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cur_nxt   = '0;
        run_nxt   = '0;
        found_nxt = 1'b0;
        if (need_total > (SW+1)'(MEM_CELLS)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_REPLY;
        end else if (size_r == '0) begin
          res_status_nxt = ST_NO_FIT;
          state_nxt      = S_REPLY;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // one cell per cycle; end of memory closes a run like a used cell
        if (!last_cell && !cell_used) begin
          run_nxt = run_r + CW'(1);
        end else begin
          if (SW'(run_r) >= SW'(size_r) && take) begin
            found_nxt    = 1'b1;
            best_len_nxt = run_r;
            best_end_nxt = cur_r[CW-1:0];
          end
          run_nxt = '0;
        end
        // position stays at the end of memory for the mark step
        if (!last_cell) begin
          cur_nxt = cur_inc[PW-1:0];
        end
        if (last_cell) begin
          if (found_r || (SW'(run_r) >= SW'(size_r))) begin
            state_nxt = S_MARK;
          end else begin
            res_status_nxt = ST_NO_FIT;
            state_nxt      = S_REPLY;
          end
        end
      end
      S_MARK: begin
        // first mark cycle loads the base from the chosen run end
        if (cnt_r == '0 && cur_r == PW'(MEM_CELLS)) begin
          cur_nxt      = PW'(base_calc);
          res_base_nxt = PW'(base_calc);
        end else begin
          wr_en   = 1'b1;
          wr_data = 1'b1;
          cnt_nxt = cnt_r + SIZE_W'(1);
          cur_nxt = cur_inc[PW-1:0];
          if (cnt_r + SIZE_W'(1) == size_r) begin
            used_nxt       = CW'(need_total);
            res_status_nxt = ST_OK;
            state_nxt      = S_REPLY;
          end
        end
      end
      S_FREE: begin
        if (cnt_r == size_r || cur_r >= PW'(MEM_CELLS)) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_REPLY;
        end else begin
          wr_en   = 1'b1;
          wr_data = 1'b0;
          if (cell_used) begin
            used_nxt = used_r - CW'(1);
          end
          cnt_nxt = cnt_r + SIZE_W'(1);
          cur_nxt = cur_inc[PW-1:0];
        end
      end
      S_REPLY: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // the scan exit may take a run that closes at the end of memory
  // in the same cycle, so the chosen end is also updated there
  // (handled above through best_end_nxt on the last cell)

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      mode_r  <= MODE_BEST;
      wrt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (cfg_we) begin
        mode_r <= cfg_fit_mode;
      end
      if (wr_en) begin
        wrt_r[wr_addr] <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    run_r        <= run_nxt;
    found_r      <= found_nxt;
    best_len_r   <= best_len_nxt;
    best_end_r   <= best_end_nxt;
    res_base_r   <= res_base_nxt;
    res_status_r <= res_status_nxt;
  end

  // cell map memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_bit_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_wrt_r <= 1'b0;
    end else begin
      rd_wrt_r <= wrt_r[rd_addr];
    end
  end

  // result register
  assign free_calc = FW'(MEM_CELLS) - FW'(used_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_REPLY && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_REPLY && slot_free) begin
      out_base_r   <= res_base_r[ABASE_W-1:0];
      out_status_r <= res_status_r;
      out_freec_r  <= free_calc[FREEC_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_alloc_base = out_base_r;
  assign out_status     = out_status_r;
  assign out_free_cells = out_freec_r;

  // checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MEM_CELLS))
    else $error("used cell count beyond memory size");

  a_rise_from_reply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_REPLY)
    else $error("result word without a reply cycle");

  a_fail_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_base_r == '0)
    else $error("failed allocate reports a nonzero base");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> PW'(run_r) <= cur_r)
    else $error("free run longer than cells scanned");

  a_mark_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MARK && wr_en |-> cur_r < PW'(MEM_CELLS))
    else $error("mark outside map");

endmodule

// ----- tb/sv/alloc_reply_checker.sv -----
`timescale 1ns / 100ps
// alloc_reply_checker: watches the request, result and configuration ports of the allocator,
// predicts every result word from its own copy of the cell map and compares them in order
// depends on cfa_pkg
module alloc_reply_checker
  import cfa_pkg::*;
#(
  parameter int unsigned CELLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_fit_mode,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [SIZE_W-1:0]   in_request_size,
  input  logic [FBASE_W-1:0]  in_free_base,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [ABASE_W-1:0]  out_alloc_base,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [FREEC_W-1:0]  out_free_cells,
  output int                  errors,
  output int                  waiting
);

  typedef struct packed {
    logic [ABASE_W-1:0] base;
    status_t            status;
    logic [FREEC_W-1:0] free_cells;
  } reply_t;

  // shadow of the allocator state
  logic [CELLS-1:0] cell_map;
  int unsigned      used_cells;
  logic             fit_policy;
  reply_t           expected_replies[$];
  int               error_tally;
  reply_t           want;

  // apply one request word to the shadow map and return the reply it earns
  function automatic reply_t serve_request(func_t fn, logic [SIZE_W-1:0] size,
                                           logic [FBASE_W-1:0] fbase);
    reply_t      r;
    int unsigned run_len;
    int unsigned pick_len;
    int unsigned pick_end;
    int unsigned base;
    bit          found;
    r.base   = '0;
    r.status = ST_OK;
    if (fn == FN_ALLOC) begin
      if (used_cells + size > CELLS) begin
        r.status = ST_FULL;
      end else begin
        found    = 1'b0;
        run_len  = 0;
        pick_len = 0;
        pick_end = 0;
        // the end of memory closes a run like a used cell does
        for (int i = 0; i <= CELLS; i++) begin
          if (i < CELLS && !cell_map[i]) begin
            run_len++;
          end else begin
            if (run_len >= size && (!found ||
                (fit_policy == MODE_BEST ? run_len <= pick_len : run_len >= pick_len))) begin
              found    = 1'b1;
              pick_len = run_len;
              pick_end = i;
            end
            run_len = 0;
          end
        end
        if (size == 0 || !found) begin
          r.status = ST_NO_FIT;
        end else begin
          // block sits at the high end of the chosen run
          base = pick_end - size;
          for (int i = 0; i < size; i++) cell_map[base + i] = 1'b1;
          used_cells += size;
          r.base = base[ABASE_W-1:0];
        end
      end
    end else begin
      // release only cells inside memory that are actually used
      for (int i = 0; i < size; i++) begin
        if (fbase + i < CELLS && cell_map[fbase + i]) begin
          cell_map[fbase + i] = 1'b0;
          used_cells--;
        end
      end
    end
    r.free_cells = FREEC_W'(CELLS - used_cells);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cell_map    = '0;
      used_cells  = 0;
      fit_policy  = MODE_BEST;
      error_tally = 0;
      expected_replies.delete();
    end else begin
      if (cfg_we) fit_policy = cfg_fit_mode;
      // result word: compare with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result word base %0d status %0d free %0d",
                   $time, out_alloc_base, out_status, out_free_cells);
          error_tally++;
        end else begin
          want = expected_replies.pop_front();
          if (out_alloc_base !== want.base) begin
            $display("%0t: alloc_base expected %0d, got %0d", $time, want.base, out_alloc_base);
            error_tally++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            error_tally++;
          end
          if (out_free_cells !== want.free_cells) begin
            $display("%0t: free_cells expected %0d, got %0d", $time, want.free_cells,
                     out_free_cells);
            error_tally++;
          end
        end
      end
      // request word: predict its reply
      if (in_valid && !in_stall) begin
        expected_replies.push_back(serve_request(in_func, in_request_size, in_free_base));
      end
    end
    errors  <= error_tally;
    waiting <= expected_replies.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: top of the allocator test, drives requests, configuration and result stalls
// depends on cfa_pkg, contiguous_fit_allocator and alloc_reply_checker
module testbench;
  import cfa_pkg::*;

  localparam int unsigned CELLS = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    func_t             fn;
    logic [SIZE_W-1:0] size;
  } sent_t;

  typedef struct {
    int unsigned base;
    int unsigned size;
  } block_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_fit_mode;
  logic                in_valid;
  logic                in_stall;
  func_t               in_func;
  logic [SIZE_W-1:0]   in_request_size;
  logic [FBASE_W-1:0]  in_free_base;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ABASE_W-1:0]  out_alloc_base;
  logic [STATUS_W-1:0] out_status;
  logic [FREEC_W-1:0]  out_free_cells;

  int                  mismatch_count;
  int                  pending_replies;
  int unsigned         cycle_count = 0;
  int unsigned         stall_left = 0;
  int unsigned         stall_roll;
  bit                  steady = 1'b0;

  // requests in flight and blocks currently held, used to pick sensible frees
  sent_t               sent_q[$];
  sent_t               done_req;
  block_t              live_blocks[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  contiguous_fit_allocator #(
    .MEM_CELLS(CELLS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_fit_mode   (cfg_fit_mode),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_request_size(in_request_size),
    .in_free_base   (in_free_base),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_alloc_base (out_alloc_base),
    .out_status     (out_status),
    .out_free_cells (out_free_cells)
  );

  alloc_reply_checker #(
    .CELLS(CELLS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_fit_mode   (cfg_fit_mode),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_request_size(in_request_size),
    .in_free_base   (in_free_base),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_alloc_base (out_alloc_base),
    .out_status     (out_status),
    .out_free_cells (out_free_cells),
    .errors         (mismatch_count),
    .waiting        (pending_replies)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side stalls: mostly short, now and then long
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (steady || stall_roll < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 4);
      end else if (stall_roll < 94) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(20, 60);
      end
    end
  end

  // track granted blocks so later frees can release them
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && sent_q.size() != 0) begin
      done_req = sent_q.pop_front();
      if (done_req.fn == FN_ALLOC && out_status == ST_OK) begin
        live_blocks.push_back('{int'(out_alloc_base), int'(done_req.size)});
      end
    end
    if (rst_n && in_valid && !in_stall) sent_q.push_back('{in_func, in_request_size});
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 80);
  endfunction

  // mostly small blocks, some large, a few out of range
  function automatic int unsigned rand_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 8);
    if (roll < 90) return $urandom_range(9, 24);
    if (roll < 97) return $urandom_range(25, 64);
    return $urandom_range(0, 127);
  endfunction

  // present one request word and hold it until taken
  task automatic issue_request(func_t fn, int unsigned size, int unsigned fbase);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_func         <= fn;
    in_request_size <= size[SIZE_W-1:0];
    in_free_base    <= fbase[FBASE_W-1:0];
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every reply is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_mode(logic mode);
    cfg_we       <= 1'b1;
    cfg_fit_mode <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned pick;
    int unsigned idx;
    block_t      blk;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_fit_mode    <= 1'b0;
    in_valid        <= 1'b0;
    in_func         <= FN_ALLOC;
    in_request_size <= '0;
    in_free_base    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: best fit on a hand-made map
    set_mode(MODE_BEST);
    issue_request(FN_ALLOC, 0, 63);    // zero size allocate
    issue_request(FN_ALLOC, 64, 0);    // whole memory
    issue_request(FN_ALLOC, 1, 0);     // nothing left
    issue_request(FN_FREE, 4, 8);
    issue_request(FN_FREE, 8, 20);
    issue_request(FN_FREE, 4, 40);
    issue_request(FN_FREE, 4, 60);     // hole touching the end of memory
    issue_request(FN_ALLOC, 3, 0);     // tie between small holes, later one wins
    issue_request(FN_ALLOC, 4, 0);
    issue_request(FN_ALLOC, 9, 0);     // enough space in total but no hole fits
    issue_request(FN_FREE, 0, 5);      // zero size free
    issue_request(FN_FREE, 6, 8);      // part of the range already free
    wait_drained();

    // directed: worst fit, range edges
    set_mode(MODE_WORST);
    issue_request(FN_ALLOC, 2, 0);
    issue_request(FN_ALLOC, 6, 0);     // equal largest holes
    issue_request(FN_FREE, 127, 63);   // range runs past the end of memory
    issue_request(FN_FREE, 64, 50);
    issue_request(FN_ALLOC, 65, 0);    // larger than memory
    issue_request(FN_FREE, 127, 0);
    issue_request(FN_ALLOC, 127, 21);
    issue_request(FN_ALLOC, 1, 42);
    issue_request(FN_FREE, 85, 42);
    issue_request(FN_FREE, 64, 0);

    // random phases, policy alternates, one phase without any idling
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      set_mode(phase % 2 == 0 ? MODE_BEST : MODE_WORST);
      steady = (phase == 3);
      for (int n = 0; n < 105; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          issue_request(FN_ALLOC, rand_size(), $urandom_range(0, 63));
        end else if (pick < 85 && live_blocks.size() != 0) begin
          idx = $urandom_range(0, live_blocks.size() - 1);
          blk = live_blocks[idx];
          live_blocks.delete(idx);
          issue_request(FN_FREE, blk.size, blk.base);
        end else begin
          issue_request(FN_FREE, rand_size(), $urandom_range(0, 63));
        end
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (3 * CELLS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
